// ===== src/prbd_pkg.sv =====
// prbd_pkg: shared constants and types for the peak/rms bucket decimator
// no dependencies; used by every module of the block by scoped names
package prbd_pkg;

  localparam int SampleBitsDef   = 16;
  localparam int FractionBitsDef = 16;
  localparam int CfgBits         = 32;  // samples_per_bucket register width
  localparam int CntBits         = 17;  // bucket sample count width
  localparam int QueueDepth      = 2;   // closed buckets waiting for the back end
  localparam logic [CfgBits-1:0] CfgResetValue = CfgBits'(32'h0001_0000);

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/prbd_front.sv =====
// prbd_front: accepts samples, tracks peak, energy, count and bucket phase
// depends on prbd_pkg; pushes each closed bucket into prbd_queue
module prbd_front #(
  parameter int SAMPLE_BITS   = prbd_pkg::SampleBitsDef,
  parameter int FRACTION_BITS = prbd_pkg::FractionBitsDef,
  parameter int EnergyBits    = 2 * SAMPLE_BITS + prbd_pkg::CntBits - 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [prbd_pkg::CfgBits-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        audio_sample_i,
  input  logic                                 end_of_stream_i,
  input  prbd_pkg::q_status_t                  q_stat_i,
  output logic                                 push_o,
  output logic [SAMPLE_BITS-1:0]               push_peak_o,
  output logic [EnergyBits-1:0]                push_energy_o,
  output logic [prbd_pkg::CntBits-1:0]         push_count_o,
  output logic                                 push_final_o
);

  localparam int PhaseBits = prbd_pkg::CfgBits + 1;
  localparam logic [PhaseBits-1:0] PhaseOne = PhaseBits'(64'd1 << FRACTION_BITS);

  logic [prbd_pkg::CfgBits-1:0] cfg_q;
  logic [SAMPLE_BITS-1:0]       peak_q, peak_d;
  logic [EnergyBits-1:0]        energy_q, energy_d;
  logic [prbd_pkg::CntBits-1:0] count_q, count_d;
  logic [PhaseBits-1:0]         phase_q, phase_d;

  logic                         accept;
  logic [SAMPLE_BITS-1:0]       mag;
  logic [2*SAMPLE_BITS-1:0]     sq;
  logic [EnergyBits:0]          esum;
  logic [PhaseBits-1:0]         size, phase_sum;
  logic                         reached, close;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    // most negative sample wraps to its true magnitude as unsigned
    mag = audio_sample_i[SAMPLE_BITS-1] ? (~audio_sample_i + 1'b1) : audio_sample_i;
    sq  = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

    peak_d = (mag > peak_q) ? mag : peak_q;
    esum   = {1'b0, energy_q} + (EnergyBits+1)'(sq);
    energy_d = esum[EnergyBits] ? '1 : esum[EnergyBits-1:0];
    count_d  = (&count_q) ? count_q : count_q + 1'b1;

    // sizes below 1.0 act as 1.0
    size = (cfg_q < PhaseOne[prbd_pkg::CfgBits-1:0]) ? PhaseOne : {1'b0, cfg_q};
    phase_sum = phase_q + PhaseOne;
    reached   = (phase_sum >= size);
    close     = reached || end_of_stream_i;

    if (end_of_stream_i) begin
      phase_d = '0;
    end else if (reached) begin
      phase_d = phase_sum - size;
    end else begin
      phase_d = phase_sum;
    end
  end

  assign push_o        = accept && close;
  assign push_peak_o   = peak_d;
  assign push_energy_o = energy_d;
  assign push_count_o  = count_d;
  assign push_final_o  = end_of_stream_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= prbd_pkg::CfgResetValue;
      peak_q   <= '0;
      energy_q <= '0;
      count_q  <= '0;
      phase_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        if (close) begin
          peak_q   <= '0;
          energy_q <= '0;
          count_q  <= '0;
        end else begin
          peak_q   <= peak_d;
          energy_q <= energy_d;
          count_q  <= count_d;
        end
      end
    end
  end

endmodule

// ===== src/prbd_queue.sv =====
// prbd_queue: short fifo of closed buckets between front and back end
// depends on prbd_pkg for depth and the status struct
module prbd_queue #(
  parameter int Width = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [Width-1:0]    push_data_i,
  input  logic                pop_i,
  output logic [Width-1:0]    pop_data_o,
  output prbd_pkg::q_status_t stat_o
);

  localparam int Depth = prbd_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/prbd_back.sv =====
// prbd_back: per bucket restoring divide energy/count, then digit-by-digit sqrt
// depends on prbd_pkg; pops from prbd_queue and holds the output beat
module prbd_back #(
  parameter int SAMPLE_BITS = prbd_pkg::SampleBitsDef,
  parameter int EnergyBits  = 2 * SAMPLE_BITS + prbd_pkg::CntBits - 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  prbd_pkg::q_status_t          q_stat_i,
  output logic                         pop_o,
  input  logic [SAMPLE_BITS-1:0]       pop_peak_i,
  input  logic [EnergyBits-1:0]        pop_energy_i,
  input  logic [prbd_pkg::CntBits-1:0] pop_count_i,
  input  logic                         pop_final_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [SAMPLE_BITS-1:0]       peak_level_o,
  output logic [SAMPLE_BITS-1:0]       rms_level_o,
  output logic                         final_bucket_o
);

  localparam int CW   = prbd_pkg::CntBits;
  localparam int StpW = $clog2(EnergyBits);
  localparam int RemW = SAMPLE_BITS + 3;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StSqrt,
    StDone
  } state_e;

  state_e                 state_q;
  logic [StpW-1:0]        step_q;
  logic [EnergyBits-1:0]  dq_q;     // dividend shifting out, quotient shifting in
  logic [CW-1:0]          div_q;
  logic [CW-1:0]          rem_q;
  logic [2*SAMPLE_BITS-1:0] op_q;
  logic [SAMPLE_BITS:0]   sr_q;
  logic [SAMPLE_BITS-1:0] root_q;

  logic [CW:0]            dv_shift;
  logic                   dv_ge;
  logic [CW:0]            dv_rem;
  logic [EnergyBits-1:0]  dq_d;
  logic [RemW-1:0]        sq_rem, sq_trial, sq_diff;
  logic                   sq_ge;

  assign pop_o = (state_q == StIdle) && !q_stat_i.empty;

  always_comb begin
    dv_shift = {rem_q, dq_q[EnergyBits-1]};
    dv_ge    = (dv_shift >= {1'b0, div_q});
    dv_rem   = dv_ge ? (dv_shift - {1'b0, div_q}) : dv_shift;
    dq_d     = {dq_q[EnergyBits-2:0], dv_ge};

    sq_rem   = {sr_q, op_q[2*SAMPLE_BITS-1 -: 2]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_ge    = (sq_rem >= sq_trial);
    sq_diff  = sq_rem - sq_trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      step_q         <= '0;
      out_valid_o    <= 1'b0;
      dq_q           <= '0;
      div_q          <= '0;
      rem_q          <= '0;
      op_q           <= '0;
      sr_q           <= '0;
      root_q         <= '0;
      peak_level_o   <= '0;
      rms_level_o    <= '0;
      final_bucket_o <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (!q_stat_i.empty) begin
            dq_q           <= pop_energy_i;
            div_q          <= pop_count_i;
            rem_q          <= '0;
            peak_level_o   <= pop_peak_i;
            final_bucket_o <= pop_final_i;
            step_q         <= StpW'(EnergyBits - 1);
            state_q        <= StDiv;
          end
        end
        StDiv: begin
          dq_q  <= dq_d;
          rem_q <= dv_rem[CW-1:0];
          if (step_q == '0) begin
            // quotient fits in twice the sample width, so low bits suffice
            op_q    <= dq_d[2*SAMPLE_BITS-1:0];
            sr_q    <= '0;
            root_q  <= '0;
            step_q  <= StpW'(SAMPLE_BITS - 1);
            state_q <= StSqrt;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        StSqrt: begin
          op_q <= {op_q[2*SAMPLE_BITS-3:0], 2'b00};
          if (sq_ge) begin
            sr_q   <= sq_diff[SAMPLE_BITS:0];
            root_q <= {root_q[SAMPLE_BITS-2:0], 1'b1};
          end else begin
            sr_q   <= sq_rem[SAMPLE_BITS:0];
            root_q <= {root_q[SAMPLE_BITS-2:0], 1'b0};
          end
          if (step_q == '0) begin
            rms_level_o <= sq_ge ? {root_q[SAMPLE_BITS-2:0], 1'b1}
                                 : {root_q[SAMPLE_BITS-2:0], 1'b0};
            out_valid_o <= 1'b1;
            state_q     <= StDone;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        StDone: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q     <= StIdle;
          out_valid_o <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/peak_rms_bucket_decimator_unit.sv =====
// peak_rms_bucket_decimator_unit: top level, front end, bucket queue, back end
// depends on prbd_pkg, prbd_front, prbd_queue, prbd_back
//
//   channel   direction  handshake                  payload
//   config    in         samples_per_bucket_we_i    samples_per_bucket_i
//   samples   in         in_valid_i / in_stall_o    audio_sample_i, end_of_stream_i
//   levels    out        out_valid_o / out_stall_i  peak_level_o, rms_level_o,
//                                                   final_bucket_o
//
// a sample that closes no bucket is handled by the front end alone; a closed bucket
// is worked off in the back end by the bit-serial divide and the two-bit-per-cycle
// square root, and the next bucket is taken only once its level beat is accepted
// the bucket queue holds two closed buckets; samples stall only when it is full
// reset is asynchronous active low and clears bucket state, phase and queue
module peak_rms_bucket_decimator_unit #(
  parameter int SAMPLE_BITS   = prbd_pkg::SampleBitsDef,
  parameter int FRACTION_BITS = prbd_pkg::FractionBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         samples_per_bucket_we_i,
  input  logic [prbd_pkg::CfgBits-1:0] samples_per_bucket_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] audio_sample_i,
  input  logic                         end_of_stream_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [SAMPLE_BITS-1:0]       peak_level_o,
  output logic [SAMPLE_BITS-1:0]       rms_level_o,
  output logic                         final_bucket_o
);

  localparam int EnergyBits = 2 * SAMPLE_BITS + prbd_pkg::CntBits - 2;
  localparam int QW = SAMPLE_BITS + EnergyBits + prbd_pkg::CntBits + 1;

  prbd_pkg::q_status_t          q_stat;
  logic                         q_push, q_pop;
  logic [SAMPLE_BITS-1:0]       push_peak, pop_peak;
  logic [EnergyBits-1:0]        push_energy, pop_energy;
  logic [prbd_pkg::CntBits-1:0] push_count, pop_count;
  logic                         push_final, pop_final;
  logic [QW-1:0]                pop_data;

  prbd_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS),
    .EnergyBits   (EnergyBits)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (samples_per_bucket_we_i),
    .cfg_data_i     (samples_per_bucket_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .audio_sample_i (audio_sample_i),
    .end_of_stream_i(end_of_stream_i),
    .q_stat_i       (q_stat),
    .push_o         (q_push),
    .push_peak_o    (push_peak),
    .push_energy_o  (push_energy),
    .push_count_o   (push_count),
    .push_final_o   (push_final)
  );

  prbd_queue #(
    .Width(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({push_peak, push_energy, push_count, push_final}),
    .pop_i      (q_pop),
    .pop_data_o (pop_data),
    .stat_o     (q_stat)
  );

  assign {pop_peak, pop_energy, pop_count, pop_final} = pop_data;

  prbd_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .EnergyBits (EnergyBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .pop_o         (q_pop),
    .pop_peak_i    (pop_peak),
    .pop_energy_i  (pop_energy),
    .pop_count_i   (pop_count),
    .pop_final_i   (pop_final),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .peak_level_o  (peak_level_o),
    .rms_level_o   (rms_level_o),
    .final_bucket_o(final_bucket_o)
  );

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_stat.full))
    else $error("bucket pushed into full queue");

  // a bucket closes only on an accepted sample
  a_push_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (in_valid_i && !in_stall_o))
    else $error("bucket closed without an accepted beat");

  // rms of a bucket can never exceed its peak
  a_rms_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rms_level_o <= peak_level_o))
    else $error("rms level above peak level");

  // back end only takes a bucket that is there
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for peak_rms_bucket_decimator_unit
// depends on prbd_pkg and the RTL of the block; predicts peak/rms levels per bucket
// and checks every level beat against them under random idling on both sides
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleW        = prbd_pkg::SampleBitsDef;
  localparam int CfgW           = prbd_pkg::CfgBits;
  localparam logic [32:0] OneSample = 33'h0_0001_0000;  // 1.0 in 16.16
  localparam logic [46:0] EnergyMax = '1;
  localparam logic [16:0] CountMax  = '1;
  localparam int SettleCycles   = 200;        // two closed buckets in the back end plus margin
  localparam int CycleLimit     = 2_000_000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               eos;
  } sample_beat_t;

  typedef struct packed {
    logic [SampleW-1:0] peak;
    logic [SampleW-1:0] rms;
    logic               last;
  } levels_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                samples_per_bucket_we_i = 1'b0;
  logic [CfgW-1:0]     samples_per_bucket_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  audio_sample_i = '0;
  logic                end_of_stream_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SampleW-1:0]  peak_level_o;
  logic [SampleW-1:0]  rms_level_o;
  logic                final_bucket_o;

  peak_rms_bucket_decimator_unit i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .samples_per_bucket_we_i(samples_per_bucket_we_i),
    .samples_per_bucket_i   (samples_per_bucket_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .audio_sample_i         (audio_sample_i),
    .end_of_stream_i        (end_of_stream_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .peak_level_o           (peak_level_o),
    .rms_level_o            (rms_level_o),
    .final_bucket_o         (final_bucket_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor state, mirrors the bucket and phase of the block
  logic [CfgW-1:0]    bucket_size = prbd_pkg::CfgResetValue;
  logic [SampleW-1:0] peak_held = '0;
  logic [46:0]        energy_held = '0;
  logic [16:0]        count_held = '0;
  logic [32:0]        phase_held = '0;

  sample_beat_t samples_to_send[$];
  sample_beat_t beat_on_bus;
  levels_t      expected_levels[$];
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [SampleW-1:0] floor_root(input logic [31:0] x);
    logic [16:0] root;
    logic [16:0] trial;
    int b;
    root = '0;
    for (b = 15; b >= 0; b--) begin
      trial = root | (17'd1 << b);
      if (34'(trial) * 34'(trial) <= 34'(x)) root = trial;
    end
    return root[SampleW-1:0];
  endfunction

  // adds one sample to the bucket; returns 1 and the levels when a bucket closes
  function automatic bit fold_sample(input sample_beat_t b, output levels_t lv);
    logic [SampleW-1:0] mag;
    logic [31:0]        sq;
    logic [47:0]        sum;
    logic [32:0]        size;
    bit                 closes;
    lv = '0;
    closes = 1'b0;
    mag = b.sample[SampleW-1] ? SampleW'(~b.sample + 1'b1) : b.sample;
    sq = 32'(mag) * 32'(mag);
    if (mag > peak_held) peak_held = mag;
    sum = {1'b0, energy_held} + 48'(sq);
    energy_held = (sum > 48'(EnergyMax)) ? EnergyMax : sum[46:0];
    if (count_held != CountMax) count_held++;
    // sizes below one sample behave as exactly one
    size = (bucket_size < CfgW'(OneSample)) ? OneSample : {1'b0, bucket_size};
    phase_held = phase_held + OneSample;
    if (phase_held >= size) begin
      phase_held = phase_held - size;
      closes = 1'b1;
    end
    if (b.eos) closes = 1'b1;
    if (closes) begin
      lv.peak = peak_held;
      lv.rms  = floor_root(32'(energy_held / {30'b0, count_held}));
      lv.last = b.eos;
      peak_held = '0;
      energy_held = '0;
      count_held = '0;
      if (b.eos) phase_held = '0;
    end
    return closes;
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    levels_t lv;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (fold_sample(beat_on_bus, lv)) expected_levels.insert(expected_levels.size(), lv);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus = samples_to_send.pop_front();
          in_valid_i      <= 1'b1;
          audio_sample_i  <= beat_on_bus.sample;
          end_of_stream_i <= beat_on_bus.eos;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // level monitor and receiver stall
  always @(posedge clk_i) begin
    levels_t got;
    levels_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        got.peak = peak_level_o;
        got.rms  = rms_level_o;
        got.last = final_bucket_o;
        if (expected_levels.size() == 0) begin
          report_mismatch("level beat with no bucket expected");
        end else begin
          want = expected_levels.pop_front();
          if (got.peak !== want.peak)
            report_mismatch($sformatf("peak_level %0d, expected %0d", got.peak, want.peak));
          if (got.rms !== want.rms)
            report_mismatch($sformatf("rms_level %0d, expected %0d", got.rms, want.rms));
          if (got.last !== want.last)
            report_mismatch($sformatf("final_bucket %0b, expected %0b", got.last, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 50;
        stall_pct = 0;
      end
      IDLE_STALL: begin
        send_idle_pct = 0;
        stall_pct = 50;
      end
      default: begin
        send_idle_pct = 38;
        stall_pct = 38;
      end
    endcase
  endtask

  task automatic write_bucket_size(input logic [CfgW-1:0] value);
    @(posedge clk_i);
    samples_per_bucket_we_i <= 1'b1;
    samples_per_bucket_i    <= value;
    bucket_size = value;
    @(posedge clk_i);
    samples_per_bucket_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every beat is sent and every level seen, then let the back end settle
  task automatic drain();
    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || in_valid_i || expected_levels.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic push_sample(input logic [SampleW-1:0] s, input logic eos);
    sample_beat_t b;
    b.sample = s;
    b.eos = eos;
    samples_to_send.insert(samples_to_send.size(), b);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SampleW'($urandom_range(16) - 8);
      default: return SampleW'($urandom);
    endcase
  endfunction

  // streams of random samples, each closed by an end-of-stream beat on average every odds
  task automatic queue_streams(input int n, input int odds);
    for (int k = 0; k < n; k++)
      push_sample(pick_sample(), $urandom_range(odds - 1) == 0);
  endtask

  initial begin
    logic [CfgW-1:0] size_list[12];
    logic [CfgW-1:0] size_now;
    size_list = '{32'h0001_0000, 32'h0000_0000, 32'h0000_FFFF, 32'h0001_8000,
                  32'h0003_3039, 32'h0004_0000, 32'h0010_0001, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0002_0000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one-sample buckets at reset size: extremes of the sample
    set_idling(IDLE_NONE);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h5555, 1'b0);
    push_sample(16'hAAAA, 1'b1);
    drain();

    // a size of zero acts as one sample
    write_bucket_size(32'h0000_0000);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b1);
    drain();

    // fractional size 2.5, final bucket lands on a close
    write_bucket_size(32'h0002_8000);
    push_sample(16'd100, 1'b0);
    push_sample(-16'sd200, 1'b0);
    push_sample(16'd300, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'd5, 1'b1);
    drain();

    // long bucket left open, then the size drops below the phase mid-stream
    write_bucket_size(32'h0028_0000);
    for (int k = 0; k < 8; k++) push_sample(pick_sample(), 1'b0);
    drain();
    write_bucket_size(32'h0001_8000);
    for (int k = 0; k < 5; k++) push_sample(pick_sample(), 1'b0);
    push_sample(pick_sample(), 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      size_now = size_list[p];
      if (p == 8) size_now = $urandom_range(32'h0008_0000, 32'h0001_0000);
      if (p == 9) size_now = $urandom;
      write_bucket_size(size_now);
      set_idling(idle_mode_e'(p % 4));
      // huge buckets close only on end of stream, so end streams often there
      queue_streams(155, (size_now >= 32'h0100_0000) ? 6 : 40);
      drain();
    end

    if (expected_levels.size() != 0)
      report_mismatch($sformatf("%0d buckets never seen", expected_levels.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
